/* design/stq_pkg.sv */
package stq_pkg;

  // default pool size, sentinel in slot 0 included
  localparam int unsigned POOL_SLOTS_DEF = 16;

  localparam logic [7:0]  TICK_STEP_RST = 8'd10;
  localparam logic [31:0] FAULT_TIME    = 32'hffff_ff00;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_TICK_STEP  = 1'b0,
    REG_SWITCH_TAG = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CMP,
    S_ADD_WALK,
    S_ADD_FIX,
    S_ADD_NEW,
    S_TICK_RD,
    S_TICK_CHK
  } state_e;

endpackage

/* design/sorted_timer_queue_core.sv */
// Sorted timer queue: a rejected add answers straight from idle; an accepted one reads
// the list, if not empty, entry by entry (S_ADD_CMP, S_ADD_WALK), relinks a predecessor
// when there is one (S_ADD_FIX) and writes the new entry (S_ADD_NEW). Tick: S_TICK_RD reads
// the head, S_TICK_CHK pops it while due, then the summary follows. One pool read per step.
// One item at a time: busy_o rises for a valid add or tick, falls as the last result shows.
// Results sit on result_valid_o for one cycle, no stall; reset (async) empties list and time.
module sorted_timer_queue_core #(
  parameter int unsigned POOL_SLOTS = stq_pkg::POOL_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start_i,
  output logic                busy_o,
  input  logic                command_i,
  input  logic [31:0]         delay_i,
  input  logic [31:0]         payload_i,
  // result channel
  output logic                result_valid_o,
  output stq_pkg::kind_e      kind_o,
  output stq_pkg::status_e    status_o,
  output logic [31:0]         expired_data_o,
  output logic                ctx_switch_o,
  output logic                time_fault_o,
  output logic                last_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import stq_pkg::*;

  localparam int unsigned SlotW = $clog2(POOL_SLOTS);

  // one pool entry: absolute target, payload, next slot in the sorted list
  typedef struct packed {
    logic [31:0]      target;
    logic [31:0]      payload;
    logic [SlotW-1:0] link;
  } entry_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  tick_step_q;
  logic [31:0] switch_tag_q;
  logic        cfg_wr;
  reg_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q  <= TICK_STEP_RST;
      switch_tag_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TICK_STEP:  tick_step_q  <= pwdata[7:0];
        REG_SWITCH_TAG: switch_tag_q <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TICK_STEP:  prdata = {24'd0, tick_step_q};
      REG_SWITCH_TAG: prdata = switch_tag_q;
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pool memory: one write port, one read port, read data registered
  // ---------------------------------------------------------------------------
  entry_t           pool_mem_q [POOL_SLOTS];
  entry_t           rd_data_q;
  logic             mem_re;
  logic [SlotW-1:0] mem_raddr;
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  entry_t           mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pool_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= pool_mem_q[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control and list state
  // ---------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [POOL_SLOTS-1:0] used_q, used_d;   // slot 0 is the sentinel, always used
  logic [SlotW-1:0] head_q, head_d;
  logic [31:0]      now_q, now_d;

  // per-item working registers
  logic [31:0]      tgt_q, tgt_d;
  logic [31:0]      pay_q, pay_d;
  logic [SlotW-1:0] slot_q, slot_d;        // slot being filled
  logic [SlotW-1:0] cur_q, cur_d;          // last entry with target below tgt (or equal, at the head)
  entry_t           cur_ent_q, cur_ent_d;
  logic [SlotW-1:0] nx_q, nx_d;            // entry whose read is in flight
  logic [SlotW-1:0] new_link_q, new_link_d;
  logic             head_upd_q, head_upd_d;
  logic             ts_q, ts_d;            // switch tag seen this tick
  logic             tf_q, tf_d;

  // result registers
  logic             res_valid_q, res_valid_d;
  kind_e            kind_q, kind_d;
  status_e          status_q, status_d;
  logic [31:0]      data_q, data_d;
  logic             ts_out_q, ts_out_d;
  logic             tf_out_q, tf_out_d;
  logic             last_q, last_d;

  // acceptance-time decode
  logic             accept;
  logic             add_invalid;
  logic             free_found;
  logic [SlotW-1:0] free_idx;
  logic [31:0]      now_tick;

  assign accept      = start_i & ~busy_o;
  // reject when delay >= 0xffffffff - now, i.e. delay >= ~now, so the target stays below 0xffffffff
  assign add_invalid = (delay_i == 32'd0) || (delay_i >= ~now_q);
  assign now_tick    = now_q + {24'd0, tick_step_q};

  // lowest free slot above the sentinel
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = POOL_SLOTS - 1; i >= 1; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_e'(command_i) == CMD_TICK) begin
            state_d = S_TICK_RD;
          end else if (!add_invalid && free_found) begin
            state_d = (head_q == '0) ? S_ADD_NEW : S_ADD_CMP;
          end
        end
      end
      S_ADD_CMP: begin
        if (rd_data_q.target > tgt_q) begin
          state_d = S_ADD_NEW;
        end else if (rd_data_q.link == '0) begin
          state_d = S_ADD_FIX;
        end else begin
          state_d = S_ADD_WALK;
        end
      end
      S_ADD_WALK: begin
        if (rd_data_q.target >= tgt_q || rd_data_q.link == '0) begin
          state_d = S_ADD_FIX;
        end
      end
      S_ADD_FIX:  state_d = S_ADD_NEW;
      S_ADD_NEW:  state_d = S_IDLE;
      S_TICK_RD:  state_d = (head_q == '0) ? S_IDLE : S_TICK_CHK;
      S_TICK_CHK: state_d = (now_q < rd_data_q.target) ? S_IDLE : S_TICK_RD;
      default:    state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath, memory control and results
  // ---------------------------------------------------------------------------
  always_comb begin
    used_d      = used_q;
    head_d      = head_q;
    now_d       = now_q;
    tgt_d       = tgt_q;
    pay_d       = pay_q;
    slot_d      = slot_q;
    cur_d       = cur_q;
    cur_ent_d   = cur_ent_q;
    nx_d        = nx_q;
    new_link_d  = new_link_q;
    head_upd_d  = head_upd_q;
    ts_d        = ts_q;
    tf_d        = tf_q;

    res_valid_d = 1'b0;
    kind_d      = kind_q;
    status_d    = status_q;
    data_d      = data_q;
    ts_out_d    = ts_out_q;
    tf_out_d    = tf_out_q;
    last_d      = last_q;

    mem_re      = 1'b0;
    mem_raddr   = head_q;
    mem_we      = 1'b0;
    mem_waddr   = slot_q;
    mem_wdata   = '{target: tgt_q, payload: pay_q, link: new_link_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_e'(command_i) == CMD_TICK) begin
            now_d = now_tick;
            tf_d  = (now_tick >= FAULT_TIME);
            ts_d  = 1'b0;
          end else if (add_invalid || !free_found) begin
            res_valid_d = 1'b1;
            kind_d      = KIND_ADD;
            status_d    = add_invalid ? STAT_INVALID : STAT_FULL;
            data_d      = '0;
            ts_out_d    = 1'b0;
            tf_out_d    = 1'b0;
            last_d      = 1'b1;
          end else begin
            tgt_d      = now_q + delay_i;
            pay_d      = payload_i;
            slot_d     = free_idx;
            new_link_d = '0;
            head_upd_d = (head_q == '0);
            // fetch the head unless the list is empty
            mem_re     = (head_q != '0);
          end
        end
      end

      S_ADD_CMP: begin
        if (rd_data_q.target > tgt_q) begin
          // new entry becomes the head
          new_link_d = head_q;
          head_upd_d = 1'b1;
        end else begin
          // head with equal target keeps its place: walk from the head
          cur_d      = head_q;
          cur_ent_d  = rd_data_q;
          new_link_d = rd_data_q.link;
          nx_d       = rd_data_q.link;
          mem_re     = (rd_data_q.link != '0);
          mem_raddr  = rd_data_q.link;
        end
      end

      S_ADD_WALK: begin
        if (rd_data_q.target >= tgt_q) begin
          new_link_d = nx_q;
        end else begin
          cur_d      = nx_q;
          cur_ent_d  = rd_data_q;
          new_link_d = rd_data_q.link;
          nx_d       = rd_data_q.link;
          mem_re     = (rd_data_q.link != '0);
          mem_raddr  = rd_data_q.link;
        end
      end

      S_ADD_FIX: begin
        // point the predecessor at the new slot
        mem_we    = 1'b1;
        mem_waddr = cur_q;
        mem_wdata = '{target: cur_ent_q.target, payload: cur_ent_q.payload, link: slot_q};
      end

      S_ADD_NEW: begin
        mem_we         = 1'b1;
        used_d[slot_q] = 1'b1;
        if (head_upd_q) begin
          head_d = slot_q;
        end
        res_valid_d = 1'b1;
        kind_d      = KIND_ADD;
        status_d    = STAT_OK;
        data_d      = '0;
        ts_out_d    = 1'b0;
        tf_out_d    = 1'b0;
        last_d      = 1'b1;
      end

      S_TICK_RD: begin
        if (head_q == '0) begin
          res_valid_d = 1'b1;
          kind_d      = KIND_SUMMARY;
          status_d    = STAT_OK;
          data_d      = '0;
          ts_out_d    = ts_q;
          tf_out_d    = tf_q;
          last_d      = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
      end

      S_TICK_CHK: begin
        if (now_q < rd_data_q.target) begin
          res_valid_d = 1'b1;
          kind_d      = KIND_SUMMARY;
          status_d    = STAT_OK;
          data_d      = '0;
          ts_out_d    = ts_q;
          tf_out_d    = tf_q;
          last_d      = 1'b1;
        end else begin
          used_d[head_q] = 1'b0;
          head_d         = rd_data_q.link;
          if (rd_data_q.payload != switch_tag_q) begin
            res_valid_d = 1'b1;
            kind_d      = KIND_EXPIRED;
            status_d    = STAT_OK;
            data_d      = rd_data_q.payload;
            ts_out_d    = 1'b0;
            tf_out_d    = 1'b0;
            last_d      = 1'b0;
          end else begin
            ts_d = 1'b1;
          end
        end
      end

      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= {{(POOL_SLOTS-1){1'b0}}, 1'b1};
      head_q      <= '0;
      now_q       <= '0;
      res_valid_q <= 1'b0;
      head_upd_q  <= 1'b0;
      ts_q        <= 1'b0;
      tf_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      head_q      <= head_d;
      now_q       <= now_d;
      res_valid_q <= res_valid_d;
      head_upd_q  <= head_upd_d;
      ts_q        <= ts_d;
      tf_q        <= tf_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    tgt_q      <= tgt_d;
    pay_q      <= pay_d;
    slot_q     <= slot_d;
    cur_q      <= cur_d;
    cur_ent_q  <= cur_ent_d;
    nx_q       <= nx_d;
    new_link_q <= new_link_d;
    kind_q     <= kind_d;
    status_q   <= status_d;
    data_q     <= data_d;
    ts_out_q   <= ts_out_d;
    tf_out_q   <= tf_out_d;
    last_q     <= last_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign status_o       = status_q;
  assign expired_data_o = data_q;
  assign ctx_switch_o   = ts_out_q;
  assign time_fault_o   = tf_out_q;
  assign last_o         = last_q;

endmodule

/* design/stq_checker.sv */
module stq_port_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_o,
  input  logic             result_valid_o,
  input  stq_pkg::kind_e   kind_o,
  input  stq_pkg::status_e status_o,
  input  logic             last_o
);
  import stq_pkg::*;

  // an accepted item either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || result_valid_o))
    else $error("item accepted but block neither busy nor answering");

  // the summary always closes a tick
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KIND_SUMMARY) |-> last_o)
    else $error("tick summary without last");

  // an expired payload is never the final result of a tick
  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KIND_EXPIRED) |-> (!last_o && status_o == STAT_OK))
    else $error("expired payload marked last or with status");

  // once the final result shows, the block is ready again
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy_o)
    else $error("busy while final result shown");

endmodule

bind sorted_timer_queue_core stq_port_checker u_stq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .status_o       (status_o),
  .last_o         (last_o)
);
